// ----- design/ort_pkg.sv -----
// Shared types and constants for the outstanding request table.
`timescale 1ns / 1ps

package ort_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0] slot_idx_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);

  // Result codes
  typedef enum logic [2:0] {
    ST_SENT       = 3'd0,
    ST_FULL       = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_MATCHED    = 3'd3,
    ST_DROPPED    = 3'd4
  } status_t;

  // Kind of input item
  typedef enum logic {
    KIND_REQUEST  = 1'b0,
    KIND_RESPONSE = 1'b1
  } req_kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_t;

  // Start command from the input side to the sequencer
  typedef struct packed {
    logic      start;
    req_kind_t kind;
    logic      misaligned;
  } seq_cmd_t;

  // Slot memory control from the sequencer
  typedef struct packed {
    logic      wr_en;
    slot_idx_t wr_addr;
    slot_idx_t rd_addr;
  } mem_ctl_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic        idle;
    logic        done;
    status_t     status;
    slot_idx_t   slot;
    logic [31:0] tag;
  } seq_res_t;

endpackage

// ----- design/ort_slot_mem.sv -----
// Slot storage for client tags and mailbox words, one write and one registered read port.
`timescale 1ns / 1ps

module ort_slot_mem (
  input  logic              clk,
  input  ort_pkg::mem_ctl_t mem_ctl,
  input  logic [31:0]       wr_tag,
  input  logic [31:0]       wr_word,
  output logic [31:0]       rd_tag,
  output logic [31:0]       rd_word
);

  logic [31:0] tag_mem  [ort_pkg::SLOTS];
  logic [31:0] word_mem [ort_pkg::SLOTS];

  // Write the claimed slot
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      tag_mem[mem_ctl.wr_addr]  <= wr_tag;
      word_mem[mem_ctl.wr_addr] <= wr_word;
    end
  end

  // Read the slot under scan
  always_ff @(posedge clk) begin
    rd_tag  <= tag_mem[mem_ctl.rd_addr];
    rd_word <= word_mem[mem_ctl.rd_addr];
  end

endmodule

// ----- design/ort_seq.sv -----
// Scan sequencer: walks the slots one per cycle through a shared slot compare.
`timescale 1ns / 1ps

module ort_seq (
  input  logic              clk,
  input  logic              rst,
  input  ort_pkg::seq_cmd_t cmd,
  input  logic              take,
  input  logic [31:0]       key,
  input  logic [31:0]       rword,
  input  logic [31:0]       rtag,
  output ort_pkg::mem_ctl_t mem_ctl,
  output ort_pkg::seq_res_t res
);

  ort_pkg::seq_state_t state, state_next;
  ort_pkg::req_kind_t  kind;
  ort_pkg::slot_idx_t  idx;
  ort_pkg::slot_idx_t  rd_idx;
  logic                rd_live;
  logic [ort_pkg::SLOTS-1:0] slot_valid;

  ort_pkg::status_t    res_status;
  ort_pkg::slot_idx_t  res_slot;
  logic [31:0]         res_tag;

  logic hit;
  logic last;
  logic finish;

  // Shared slot compare: free slot for a request, live matching word for a response
  always_comb begin
    if (kind == ort_pkg::KIND_REQUEST) begin
      hit = !slot_valid[rd_idx];
    end else begin
      hit = slot_valid[rd_idx] && (rword == key);
    end
    last   = (rd_idx == ort_pkg::LAST_SLOT);
    finish = (state == ort_pkg::S_SCAN) && rd_live && (hit || last);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ort_pkg::S_IDLE: begin
        if (cmd.start) begin
          state_next = cmd.misaligned ? ort_pkg::S_DONE : ort_pkg::S_SCAN;
        end
      end
      ort_pkg::S_SCAN: begin
        if (finish) begin
          state_next = ort_pkg::S_DONE;
        end
      end
      ort_pkg::S_DONE: begin
        if (take) begin
          state_next = ort_pkg::S_IDLE;
        end
      end
      default: state_next = ort_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    mem_ctl.rd_addr = idx;
    mem_ctl.wr_addr = rd_idx;
    mem_ctl.wr_en   = finish && hit && (kind == ort_pkg::KIND_REQUEST);
    res.idle        = (state == ort_pkg::S_IDLE);
    res.done        = (state == ort_pkg::S_DONE);
    res.status      = res_status;
    res.slot        = res_slot;
    res.tag         = res_tag;
  end

  // Control state and slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ort_pkg::S_IDLE;
      rd_live    <= 1'b0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      if (state == ort_pkg::S_IDLE) begin
        rd_live <= 1'b0;
      end else if (state == ort_pkg::S_SCAN) begin
        rd_live <= 1'b1;
      end
      if (finish && hit) begin
        slot_valid[rd_idx] <= (kind == ort_pkg::KIND_REQUEST);
      end
    end
  end

  // Scan index, item kind and result payload
  always_ff @(posedge clk) begin
    if (state == ort_pkg::S_IDLE && cmd.start) begin
      idx        <= '0;
      rd_idx     <= '0;
      kind       <= cmd.kind;
      res_status <= ort_pkg::ST_MISALIGNED;
      res_slot   <= '0;
      res_tag    <= '0;
    end else if (state == ort_pkg::S_SCAN) begin
      // advance the read address, hold at the last slot
      idx    <= (idx == ort_pkg::LAST_SLOT) ? idx : idx + 1'b1;
      rd_idx <= idx;
      if (finish) begin
        res_slot <= '0;
        res_tag  <= '0;
        if (hit && kind == ort_pkg::KIND_REQUEST) begin
          res_status <= ort_pkg::ST_SENT;
          res_slot   <= rd_idx;
        end else if (hit) begin
          res_status <= ort_pkg::ST_MATCHED;
          res_slot   <= rd_idx;
          res_tag    <= rtag;
        end else if (kind == ort_pkg::KIND_REQUEST) begin
          res_status <= ort_pkg::ST_FULL;
        end else begin
          res_status <= ort_pkg::ST_DROPPED;
        end
      end
    end
  end

endmodule

// ----- design/outstanding_request_table_unit.sv -----
// Top level of the outstanding request table: stream ports, counters and output register.
//
// Usage:
//   Input items arrive on s_axis_*; tuser carries the kind (0 request, 1 response).
//   A request claims the lowest free slot of 16 and returns the word to send
//   (address OR channel); a response frees the lowest slot holding its word and
//   returns the stored client tag, or counts a drop. Misaligned addresses and a
//   full table are reported in the status code on m_axis_tuser.
//   Exactly one result item leaves on m_axis_* for every accepted input item.
//   Misaligned requests go straight to the result without a scan. Other items scan
//   the slots one per cycle through one compare unit fed by the slot memory's
//   registered read port; a scan stops at the first hit or at the last slot, so a
//   full table or a dropped response is only reported after every slot is read.
//   s_axis_tready is high only while the scan sequencer is idle, so one item is
//   worked at a time and the next one is taken once its result leaves the sequencer.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, a finished result waits in the sequencer
//   until the output register frees, and no new item is taken meanwhile.
//   Reset empties the table and clears both response counters.
`timescale 1ns / 1ps

module outstanding_request_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // client_tag[31:0], block_address[63:32], channel[67:64], response_word[99:68]
  input  logic [103:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mailbox_word[31:0], released_tag[63:32], slot_index[67:64],
  // received_count[99:68], dropped_count[131:100]
  output logic [135:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser
);

  ort_pkg::seq_cmd_t cmd;
  ort_pkg::seq_res_t res;
  ort_pkg::mem_ctl_t mem_ctl;

  logic        in_take;
  logic        load;
  logic [31:0] item_tag;
  logic [31:0] item_key;
  logic [31:0] rd_tag;
  logic [31:0] rd_word;
  logic [31:0] seen;
  logic [31:0] lost;
  logic [31:0] seen_next;
  logic [31:0] lost_next;

  ort_pkg::status_t   out_status;
  logic [31:0]        out_word;
  logic [31:0]        out_tag;
  logic [3:0]         out_slot;

  // Accept an item while the sequencer is idle
  assign s_axis_tready = res.idle;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.start      = in_take;
    cmd.kind       = ort_pkg::req_kind_t'(s_axis_tuser[0]);
    cmd.misaligned = (s_axis_tuser[0] == ort_pkg::KIND_REQUEST)
                     && (s_axis_tdata[35:32] != 4'h0);
  end

  // Capture the tag and the key word to store or match
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_tag <= s_axis_tdata[31:0];
      if (s_axis_tuser[0] == ort_pkg::KIND_RESPONSE) begin
        item_key <= s_axis_tdata[99:68];
      end else begin
        item_key <= s_axis_tdata[63:32] | {28'h0, s_axis_tdata[67:64]};
      end
    end
  end

  ort_slot_mem u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_tag  (item_tag),
    .wr_word (item_key),
    .rd_tag  (rd_tag),
    .rd_word (rd_word)
  );

  ort_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .take    (load),
    .key     (item_key),
    .rword   (rd_word),
    .rtag    (rd_tag),
    .mem_ctl (mem_ctl),
    .res     (res)
  );

  // Move a finished result into the output register when it is free
  assign load = res.done && (!m_axis_tvalid || m_axis_tready);

  // Count responses after this item
  always_comb begin
    seen_next = seen;
    lost_next = lost;
    if (res.status == ort_pkg::ST_MATCHED || res.status == ort_pkg::ST_DROPPED) begin
      seen_next = seen + 32'd1;
    end
    if (res.status == ort_pkg::ST_DROPPED) begin
      lost_next = lost + 32'd1;
    end
  end

  // Output valid and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      seen          <= '0;
      lost          <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        seen          <= seen_next;
        lost          <= lost_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res.status;
      out_word   <= (res.status == ort_pkg::ST_SENT) ? item_key : 32'h0;
      out_tag    <= res.tag;
      out_slot   <= 4'(res.slot);
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'h0, lost, seen, out_slot, out_tag, out_word};

  // A busy sequencer never shows ready
  assert property (@(posedge clk) disable iff (rst) res.done |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // A loaded result is presented next cycle
  assert property (@(posedge clk) disable iff (rst) load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // A drop advances both counters by one
  assert property (@(posedge clk) disable iff (rst)
    load && res.status == ort_pkg::ST_DROPPED
    |=> lost == $past(lost) + 32'd1 && seen == $past(seen) + 32'd1)
    else $error("drop not counted");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the outstanding request table unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int LONG_HOLD      = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 1325;

  // One input item plus sender pacing marks
  typedef struct {
    ort_pkg::req_kind_t kind;
    logic [31:0]        tag;
    logic [31:0]        addr;
    logic [3:0]         chan;
    logic [31:0]        resp;
    bit                 drain;
    bit                 hold_rx;
  } mbx_item_t;

  // One expected result item
  typedef struct {
    ort_pkg::status_t status;
    logic [31:0]      word;
    logic [31:0]      tag;
    logic [3:0]       slot;
    logic [31:0]      seen;
    logic [31:0]      lost;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  outstanding_request_table_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predicted table contents and counters
  bit          occ      [ort_pkg::SLOTS];
  logic [31:0] occ_tag  [ort_pkg::SLOTS];
  logic [31:0] occ_word [ort_pkg::SLOTS];
  logic [31:0] resp_seen = '0;
  logic [31:0] resp_lost = '0;

  mbx_item_t   stim_q [$];
  outcome_t    pending_outcomes [$];
  logic [31:0] live_words [$];
  mbx_item_t   offered;
  bit          in_took = 1'b0;
  bit          mark_drain = 1'b0;
  bit          mark_hold = 1'b0;
  int          gap_left = 0;
  int          tx_calm = 0;
  int          stall_left = 0;
  int          rx_calm = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          quiet_cycles = 0;
  int          errors = 0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Mostly short idle spans, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one item to the predicted table and return its result
  function automatic outcome_t apply_to_slots(mbx_item_t it);
    outcome_t o;
    int       hit;
    o.status = ort_pkg::ST_DROPPED;
    o.word   = '0;
    o.tag    = '0;
    o.slot   = '0;
    hit      = -1;
    if (it.kind == ort_pkg::KIND_REQUEST) begin
      if (it.addr[3:0] != 4'd0) begin
        o.status = ort_pkg::ST_MISALIGNED;
      end else begin
        for (int i = 0; i < ort_pkg::SLOTS; i++)
          if (!occ[i] && hit < 0) hit = i;
        if (hit < 0) begin
          o.status = ort_pkg::ST_FULL;
        end else begin
          occ[hit]      = 1'b1;
          occ_tag[hit]  = it.tag;
          occ_word[hit] = it.addr | {28'd0, it.chan};
          o.status      = ort_pkg::ST_SENT;
          o.word        = occ_word[hit];
          o.slot        = 4'(hit);
        end
      end
    end else begin
      resp_seen = resp_seen + 32'd1;
      for (int i = 0; i < ort_pkg::SLOTS; i++)
        if (occ[i] && occ_word[i] == it.resp && hit < 0) hit = i;
      if (hit < 0) begin
        resp_lost = resp_lost + 32'd1;
        o.status  = ort_pkg::ST_DROPPED;
      end else begin
        occ[hit] = 1'b0;
        o.status = ort_pkg::ST_MATCHED;
        o.tag    = occ_tag[hit];
        o.slot   = 4'(hit);
      end
    end
    o.seen = resp_seen;
    o.lost = resp_lost;
    return o;
  endfunction

  // Queue a request; track which words the table will hold
  task automatic add_request(input logic [31:0] tag, input logic [31:0] addr,
                             input logic [3:0] chan);
    mbx_item_t it;
    it.kind    = ort_pkg::KIND_REQUEST;
    it.tag     = tag;
    it.addr    = addr;
    it.chan    = chan;
    it.resp    = $urandom;
    it.drain   = mark_drain;
    it.hold_rx = mark_hold;
    mark_drain = 1'b0;
    mark_hold  = 1'b0;
    if (addr[3:0] == 4'd0 && live_words.size() < ort_pkg::SLOTS)
      live_words.push_back(addr | {28'd0, chan});
    stim_q.push_back(it);
  endtask

  // Queue a response; ignored fields carry random values
  task automatic add_response(input logic [31:0] word);
    mbx_item_t it;
    it.kind    = ort_pkg::KIND_RESPONSE;
    it.tag     = $urandom;
    it.addr    = $urandom;
    it.chan    = 4'($urandom);
    it.resp    = word;
    it.drain   = mark_drain;
    it.hold_rx = mark_hold;
    mark_drain = 1'b0;
    mark_hold  = 1'b0;
    for (int i = 0; i < live_words.size(); i++)
      if (live_words[i] == word) begin
        live_words.delete(i);
        break;
      end
    stim_q.push_back(it);
  endtask

  // Drive input items at the falling edge
  always @(negedge clk) begin
    mbx_item_t nxt;
    if (!rst && (!s_axis_tvalid || in_took)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() == 0 ||
                   (stim_q[0].drain && pending_outcomes.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = stim_q.pop_front();
        offered <= nxt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, nxt.resp, nxt.chan, nxt.addr, nxt.tag};
        s_axis_tuser <= nxt.kind;
        if (nxt.hold_rx) hold_requests <= hold_requests + 1;
        if (tx_calm > 0) begin
          tx_calm <= tx_calm - 1;
          gap_left <= 0;
        end else begin
          gap_left <= pick_gap();
          if ($urandom_range(0, 49) == 0) tx_calm <= $urandom_range(20, 60);
        end
      end
    end
  end

  // Drive receiver readiness at the falling edge
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      m_axis_tready <= 1'b0;
      stall_left <= LONG_HOLD;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm > 0) begin
      m_axis_tready <= 1'b1;
      rx_calm <= rx_calm - 1;
    end else if (r < 3) begin
      m_axis_tready <= 1'b1;
      rx_calm <= $urandom_range(30, 120);
    end else if (r < 35) begin
      m_axis_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Record accepted items, check results, watch for a hang
  always @(posedge clk) begin
    outcome_t want;
    bit       moved;
    moved = 1'b0;
    in_took <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (pending_outcomes.size() == 0) begin
          flag_error($sformatf("result item with none expected, status %0d",
                               m_axis_tuser));
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 32'(m_axis_tuser), 32'(want.status));
          check_field("mailbox_word", m_axis_tdata[31:0], want.word);
          check_field("released_tag", m_axis_tdata[63:32], want.tag);
          check_field("slot_index", 32'(m_axis_tdata[67:64]), 32'(want.slot));
          check_field("received_count", m_axis_tdata[99:68], want.seen);
          check_field("dropped_count", m_axis_tdata[131:100], want.lost);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        pending_outcomes.push_back(apply_to_slots(offered));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Build stimulus, release reset, wait for the drain, report
  initial begin
    bit          fill_bias;
    int          r;
    logic [31:0] a;
    fill_bias = 1'b1;

    // Directed: empty-table drop, misaligned requests, field extremes
    add_response(32'h0000_0000);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    add_request(32'h0000_0000, 32'h0000_0008, 4'h0);
    add_request(32'h0000_0000, 32'h0000_0000, 4'h0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFF0, 4'hF);
    // Duplicate words: the lower slot frees first
    add_request(32'h1234_5678, 32'h0000_0000, 4'h0);
    add_response(32'h0000_0000);
    add_response(32'h0000_0000);
    // Fill the table, overflow it, then misaligned on a full table, then free a slot
    for (int i = 0; i < 15; i++)
      add_request($urandom, {28'($urandom_range(0, 268435455)), 4'h0}, 4'($urandom));
    add_request($urandom, 32'h0000_1230, 4'h5);
    add_request($urandom, 32'h0000_1234, 4'h5);
    add_response(32'hFFFF_FFFF);

    // Random: responses mostly match a live word, phases of fill and drain
    mark_drain = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 59) fill_bias = !fill_bias;
      if (i % 200 == 199) mark_drain = 1'b1;
      if (i == 300 || i == 900) mark_hold = 1'b1;
      r = $urandom_range(0, 99);
      if (r < (fill_bias ? 70 : 30)) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          a = $urandom;
          if (a[3:0] == 4'd0) a[3:0] = 4'($urandom_range(1, 15));
          add_request($urandom, a, 4'($urandom));
        end else if (r < 30) begin
          add_request($urandom, {28'($urandom_range(0, 3)), 4'h0},
                      4'($urandom_range(0, 1)));
        end else begin
          add_request($urandom, $urandom & 32'hFFFF_FFF0, 4'($urandom));
        end
      end else begin
        r = $urandom_range(0, 99);
        if (live_words.size() != 0 && r < 80)
          add_response(live_words[$urandom_range(0, live_words.size() - 1)]);
        else if (live_words.size() != 0 && r < 88)
          add_response(live_words[$urandom_range(0, live_words.size() - 1)] ^
                       (32'd1 << $urandom_range(0, 31)));
        else
          add_response($urandom);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(stim_q.size() == 0 && !s_axis_tvalid && pending_outcomes.size() == 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- outstanding_request_table_unit.f -----
design/ort_pkg.sv
design/ort_slot_mem.sv
design/ort_seq.sv
design/outstanding_request_table_unit.sv
tb/tb_top.sv
